FILE: hw/rtl/keyed_bitmap_set_table_defines.svh
// assertion macros used by keyed_bitmap_set_table
`ifndef KEYED_BITMAP_SET_TABLE_DEFINES_SVH
`define KEYED_BITMAP_SET_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, reset masks the check
`define KBST_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, reset masks the check
`define KBST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KBST_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define KBST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/kbst_pkg.sv
package kbst_pkg;

	// table geometry
	localparam int NUM_KEYS    = 256;
	localparam int KEY_W       = $clog2(NUM_KEYS);
	localparam int MAX_ID      = 64;
	localparam int ID_W        = 7;
	localparam int CNT_W       = 7;
	localparam int BIT_IDX_W   = $clog2(MAX_ID);
	localparam int ENTRY_W     = CNT_W + MAX_ID;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [MAX_ID-1:0] bitmap_t;

	// one table row
	typedef struct packed {
		cnt_t    count;
		bitmap_t bits;
	} entry_t;

	// command codes
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_QUERY  = 1'b1
	} cmd_t;

	localparam id_t LIMIT_RESET = id_t'(MAX_ID);
	localparam id_t MAX_ID_V    = id_t'(MAX_ID);

endpackage

FILE: hw/rtl/kbst_req_if.sv
interface kbst_req_if;
	import kbst_pkg::*;

	logic valid;
	logic ready;
	logic cmd;
	key_t key;
	id_t  member_id;

	modport source (output valid, output cmd, output key, output member_id, input ready);
	modport sink   (input valid, input cmd, input key, input member_id, output ready);

endinterface

FILE: hw/rtl/kbst_rsp_if.sv
interface kbst_rsp_if;
	import kbst_pkg::*;

	logic valid;
	logic ready;
	cnt_t set_count;
	id_t  found_id;
	logic has_id;
	logic last;

	modport source (output valid, output set_count, output found_id, output has_id,
		output last, input ready);
	modport sink   (input valid, input set_count, input found_id, input has_id,
		input last, output ready);

endinterface

FILE: hw/rtl/kbst_ram.sv
module kbst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/keyed_bitmap_set_table.sv
// insert: row read, then conditional write-back; no result beat
// query: row read, then the bitmap scan, then a flush step that shows the last beat;
// the bitmap is scanned one id per cycle by a single shift-and-test step,
// except while a found id waits for the result side to take the beat before
// it; one item in flight at a time; ready is high only between items
// reset: per-row valid flops clear at once so every row reads as empty,
// id_limit returns to 64; no clearing pass, ready right after reset
module keyed_bitmap_set_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  kbst_pkg::id_t    cfg_wdata,
	kbst_req_if.sink         req,
	kbst_rsp_if.source       rsp
);
	import kbst_pkg::*;

	`include "keyed_bitmap_set_table_defines.svh"

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t              state_q;
	id_t                 id_limit_q;
	logic [NUM_KEYS-1:0] row_vld_q;
	logic                row_vld_rd_q;

	logic    cmd_q;
	key_t    key_q;
	id_t     id_q;
	id_t     lim_q;
	cnt_t    cnt_q;
	bitmap_t bits_q;
	id_t     idx_q;
	logic    pend_vld_q;
	id_t     pend_id_q;

	logic out_vld_q;
	cnt_t out_cnt_q;
	id_t  out_id_q;
	logic out_has_q;
	logic out_last_q;

	logic   req_beat;
	id_t    eff_lim;
	entry_t rd_entry;
	entry_t ram_rd;
	entry_t wr_entry;
	logic   wr_en;
	id_t    id_m1;
	logic   id_ok;
	logic   out_free;
	logic   scan_done;
	logic   emit;
	id_t    emit_id;
	logic   emit_has;
	logic   emit_last;
	logic   advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			id_limit_q <= cfg_wdata;
		end
	end

	assign eff_lim  = (id_limit_q > MAX_ID_V) ? MAX_ID_V : id_limit_q;
	assign req.ready = (state_q == ST_IDLE);
	assign req_beat  = req.valid && req.ready;

	// table storage
	kbst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_KEYS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (key_q),
		.wr_data (wr_entry),
		.rd_en   (req_beat),
		.rd_addr (req.key),
		.rd_data (ram_rd)
	);

	// rows never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			row_vld_rd_q <= 1'b0;
		end else begin
			if (req_beat) begin
				row_vld_rd_q <= row_vld_q[req.key];
			end
			if (wr_en) begin
				row_vld_q[key_q] <= 1'b1;
			end
		end
	end

	assign rd_entry = row_vld_rd_q ? ram_rd : '0;

	// insert read-modify-write
	assign id_m1 = id_q - id_t'(1);
	assign id_ok = (id_q != '0) && (id_q <= lim_q);
	assign wr_en = (state_q == ST_READ) && (cmd_q == CMD_INSERT) && id_ok
		&& !rd_entry.bits[id_m1[BIT_IDX_W-1:0]];
	always_comb begin
		wr_entry       = rd_entry;
		wr_entry.bits  = rd_entry.bits | (bitmap_t'(1) << id_m1[BIT_IDX_W-1:0]);
		wr_entry.count = rd_entry.count + cnt_t'(1);
	end

	// scan step and result emission
	assign out_free  = !out_vld_q || rsp.ready;
	assign scan_done = idx_q > lim_q;

	always_comb begin
		emit      = 1'b0;
		emit_id   = pend_id_q;
		emit_has  = 1'b1;
		emit_last = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				if (!scan_done) begin
					if (bits_q[0] && pend_vld_q) begin
						emit    = out_free;
						advance = out_free;
					end else begin
						advance = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				emit      = out_free;
				emit_id   = pend_vld_q ? pend_id_q : '0;
				emit_has  = pend_vld_q;
				emit_last = 1'b1;
			end
			ST_IDLE, ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_beat) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					pend_vld_q <= 1'b0;
					state_q    <= (cmd_q == CMD_QUERY) ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FLUSH;
					end else if (advance && bits_q[0]) begin
						pend_vld_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and scan datapath
	always_ff @(posedge clk) begin
		if (req_beat) begin
			cmd_q <= req.cmd;
			key_q <= req.key;
			id_q  <= req.member_id;
			lim_q <= eff_lim;
		end
		if (state_q == ST_READ) begin
			cnt_q  <= rd_entry.count;
			bits_q <= rd_entry.bits;
			idx_q  <= id_t'(1);
		end else if (advance) begin
			bits_q <= bits_q >> 1;
			idx_q  <= idx_q + id_t'(1);
			if (bits_q[0]) begin
				pend_id_q <= idx_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_cnt_q  <= cnt_q;
			out_id_q   <= emit_id;
			out_has_q  <= emit_has;
			out_last_q <= emit_last;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.set_count = out_cnt_q;
	assign rsp.found_id  = out_id_q;
	assign rsp.has_id    = out_has_q;
	assign rsp.last      = out_last_q;

	// checks
	`KBST_ASSERT(a_wr_only_insert, clk, arst_n, wr_en,
		(state_q == ST_READ) && (cmd_q == CMD_INSERT), "table write outside insert")
	`KBST_ASSERT(a_id_has_match, clk, arst_n, out_vld_q,
		out_has_q == (out_id_q != '0), "found_id and has_id disagree")
	`KBST_ASSERT(a_empty_is_last, clk, arst_n, out_vld_q && !out_has_q,
		out_last_q, "no-id beat not flagged last")
	`KBST_ASSERT(a_pend_below_idx, clk, arst_n, (state_q == ST_SCAN) && pend_vld_q,
		pend_id_q < idx_q, "pending id not below scan index")
	`KBST_ASSERT_NXT(a_emit_shows, clk, arst_n, emit, out_vld_q,
		"emitted beat not presented")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import kbst_pkg::*;

	localparam int MAX_CYCLES    = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int REPORT_MAX    = 10;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one result beat of a query
	typedef struct packed {
		cnt_t set_count;
		id_t  found_id;
		logic has_id;
		logic last;
	} scan_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	id_t  cfg_wdata;

	kbst_req_if req_ch ();
	kbst_rsp_if rsp_ch ();

	keyed_bitmap_set_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// shadow copy of the table and the limit register
	bitmap_t    row_bits [NUM_KEYS];
	cnt_t       row_count [NUM_KEYS];
	id_t        limit_now;
	scan_beat_t pending_beats [$];

	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;
	bit          hold_active;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned queries_sent;
	int unsigned beats_checked;
	int unsigned limits_written;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				pending_beats.size());
			$display("[keyed_bitmap_set_table] ERROR");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	initial begin
		hold_active = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_req = 1'b0;
			end
		end
	end

	// result side ready with random stalls
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// compare each accepted beat against the oldest expectation
	always @(posedge clk) begin : check_beats
		scan_beat_t want;
		scan_beat_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.set_count, rsp_ch.found_id, rsp_ch.has_id, rsp_ch.last};
			beats_checked++;
			if (pending_beats.size() == 0) begin
				note_mismatch($sformatf("unexpected beat count=%0d id=%0d has=%0d last=%0d",
					got.set_count, got.found_id, got.has_id, got.last));
			end else begin
				want = pending_beats.pop_front();
				if (got !== want)
					note_mismatch($sformatf(
						"expected count/id/has/last %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
						want.set_count, want.found_id, want.has_id, want.last,
						got.set_count, got.found_id, got.has_id, got.last));
			end
		end
	end

	// update the shadow table and queue the beats a query gives
	task automatic apply_to_table(input cmd_t c, input key_t k, input id_t m);
		int unsigned eff;
		int unsigned n;
		eff = (limit_now > MAX_ID) ? MAX_ID : limit_now;
		n = 0;
		if (c == CMD_INSERT) begin
			if (m >= 1 && m <= eff && !row_bits[k][m-1]) begin
				row_bits[k][m-1] = 1'b1;
				row_count[k] = row_count[k] + 1'b1;
			end
		end else begin
			queries_sent++;
			for (int i = 1; i <= eff; i++) begin
				if (row_bits[k][i-1]) begin
					pending_beats.push_back('{row_count[k], id_t'(i), 1'b1, 1'b0});
					n++;
				end
			end
			if (n == 0)
				pending_beats.push_back('{row_count[k], id_t'(0), 1'b0, 1'b1});
			else
				pending_beats[$].last = 1'b1;
		end
	endtask

	// offer one item, keeping valid high when the next one follows at once
	task automatic send_item(input cmd_t c, input key_t k, input id_t m);
		int unsigned gap;
		gap = 0;
		if ($urandom_range(99) < send_gap_pct)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= c;
		req_ch.key       <= k;
		req_ch.member_id <= m;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		apply_to_table(c, k, m);
		items_sent++;
	endtask

	// wait until every expected beat is in and a pending insert has settled
	task automatic drain_block();
		req_ch.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input id_t v);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_now = v;
		limits_written++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct = 54;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct = 0;
				recv_stall_pct = 54;
			end
			default: begin
				send_gap_pct = 31;
				recv_stall_pct = 31;
			end
		endcase
	endtask

	// edge keys, edge ids, duplicates and out-of-range ids
	task automatic test_directed_basics();
		send_item(CMD_QUERY, 8'd0, 7'd0);
		send_item(CMD_INSERT, 8'd0, 7'd1);
		send_item(CMD_INSERT, 8'd0, 7'd64);
		send_item(CMD_INSERT, 8'd0, 7'd1);
		send_item(CMD_INSERT, 8'd0, 7'd0);
		send_item(CMD_INSERT, 8'd0, 7'd65);
		send_item(CMD_INSERT, 8'd0, 7'd127);
		send_item(CMD_QUERY, 8'd0, 7'd127);
		send_item(CMD_QUERY, 8'd255, 7'd0);
		send_item(CMD_INSERT, 8'd255, 7'd42);
		send_item(CMD_INSERT, 8'd255, 7'd21);
		send_item(CMD_QUERY, 8'd255, 7'd85);
	endtask

	// limit of zero, limit above the id range, limit lowered after inserts
	task automatic test_limit_extremes();
		write_limit(7'd0);
		send_item(CMD_INSERT, 8'd5, 7'd1);
		send_item(CMD_QUERY, 8'd0, 7'd0);
		send_item(CMD_QUERY, 8'd5, 7'd0);
		write_limit(7'd127);
		send_item(CMD_INSERT, 8'd5, 7'd64);
		send_item(CMD_INSERT, 8'd5, 7'd65);
		send_item(CMD_QUERY, 8'd5, 7'd0);
		write_limit(7'd1);
		send_item(CMD_INSERT, 8'd5, 7'd2);
		send_item(CMD_QUERY, 8'd0, 7'd0);
		send_item(CMD_QUERY, 8'd5, 7'd0);
		write_limit(LIMIT_RESET);
		send_item(CMD_QUERY, 8'd5, 7'd0);
	endtask

	// every id into one key in shuffled order, then read it back
	task automatic test_full_row(input key_t k);
		id_t order [MAX_ID];
		id_t tmp;
		int unsigned j;
		for (int i = 0; i < MAX_ID; i++)
			order[i] = id_t'(i + 1);
		for (int i = MAX_ID - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i])
			send_item(CMD_INSERT, k, order[i]);
		send_item(CMD_QUERY, k, 7'd0);
	endtask

	// hold the result side while items keep coming
	task automatic test_backpressure(input key_t k);
		set_idling(IDLE_NONE);
		hold_req = 1'b1;
		send_item(CMD_QUERY, k, 7'd0);
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 2)
				send_item(CMD_QUERY, k, 7'd0);
			else
				send_item(CMD_INSERT, key_t'($urandom_range(255)), id_t'($urandom_range(1, 64)));
		end
		drain_block();
	endtask

	// mostly inserts and queries on a small pool of keys so the sets grow
	task automatic test_random_traffic(input idle_mode_t mode, input id_t lim, input int count);
		key_t        pool [8];
		int unsigned r;
		key_t        k;
		id_t         m;
		write_limit(lim);
		set_idling(mode);
		foreach (pool[i])
			pool[i] = key_t'($urandom_range(255));
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			k = pool[$urandom_range(7)];
			if ($urandom_range(99) < 85)
				m = id_t'($urandom_range(1, 64));
			else
				m = id_t'($urandom_range(127));
			if (r < 65)
				send_item(CMD_INSERT, k, m);
			else if (r < 92)
				send_item(CMD_QUERY, k, m);
			else if (r < 96)
				send_item(CMD_INSERT, key_t'($urandom_range(255)), m);
			else
				send_item(CMD_QUERY, key_t'($urandom_range(255)), m);
		end
		drain_block();
	endtask

	// test sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_INSERT;
		req_ch.key = '0;
		req_ch.member_id = '0;
		hold_req = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		items_sent = 0;
		queries_sent = 0;
		beats_checked = 0;
		limits_written = 0;
		limit_now = LIMIT_RESET;
		for (int i = 0; i < NUM_KEYS; i++) begin
			row_bits[i] = '0;
			row_count[i] = '0;
		end
		set_idling(IDLE_NONE);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_limit_extremes();
		write_limit(MAX_ID_V);
		test_full_row(8'd128);
		test_backpressure(8'd128);
		test_random_traffic(IDLE_NONE, MAX_ID_V, 45);
		test_random_traffic(IDLE_SEND, id_t'($urandom_range(1, 63)), 45);
		test_random_traffic(IDLE_RECV, 7'd127, 45);
		test_random_traffic(IDLE_BOTH, id_t'($urandom_range(65, 126)), 45);
		test_random_traffic(IDLE_BOTH, 7'd0, 10);
		test_random_traffic(IDLE_RECV, MAX_ID_V, 37);

		drain_block();
		repeat (20) @(posedge clk);
		mismatches += pending_beats.size();
		$display("sent %0d items (%0d queries) over %0d limit settings", items_sent,
			queries_sent, limits_written);
		$display("checked %0d result beats, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0)
			$display("[keyed_bitmap_set_table] OK");
		else
			$display("[keyed_bitmap_set_table] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/kbst_pkg.sv
hw/rtl/kbst_req_if.sv
hw/rtl/kbst_rsp_if.sv
hw/rtl/kbst_ram.sv
hw/rtl/keyed_bitmap_set_table.sv
tb/tb_top.sv
